[rtl/core/ads_pkg.sv]
package ads_pkg;

  localparam int unsigned SWITCH_ATTEMPTS = 5;
  localparam int unsigned RETRY_GAP_MS    = 777;
  localparam int unsigned HOLD_MS         = 300000;
  localparam int unsigned MS_PER_S        = 1000;

  localparam int unsigned MsW      = 19;
  localparam int unsigned SecMsW   = 18;
  localparam int unsigned AttemptW = $clog2(SWITCH_ATTEMPTS + 1);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_INITIAL_DELAY  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_DELAY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TRIES      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_INTERVAL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BURN_TIME      = 3'd4;

  typedef struct packed {
    logic switch_ok;
    logic inhibit_cmd;
  } ads_in_t;

  typedef struct packed {
    logic        cmd_valid;
    logic        cmd_turn_on;
    logic [1:0]  cmd_switch;
    logic [3:0]  burners_on;
    logic [2:0]  phase_code;
    logic [7:0]  tries_used;
    logic        enabled_flag;
    logic [15:0] wait_left_s;
  } ads_out_t;

  // Configuration as seen by the sequencer, with the millisecond limits
  // already worked out when the register is written.
  typedef struct packed {
    logic [15:0]       initial_delay_s;
    logic [15:0]       retry_delay_s;
    logic [7:0]        max_tries;
    logic [7:0]        check_s;
    logic [SecMsW-1:0] check_ms;
    logic [SecMsW-1:0] burn_ms;
  } ads_cfg_t;

endpackage

[rtl/core/ads_cfg.sv]
module ads_cfg import ads_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output ads_cfg_t            cfg_o
);

  ads_cfg_t   cfg_q, cfg_d;
  logic [7:0] check_eff;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // An interval of zero behaves as one second.
  assign check_eff = (cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INITIAL_DELAY: cfg_d.initial_delay_s = cfg_data_i;
        CFG_RETRY_DELAY:   cfg_d.retry_delay_s   = cfg_data_i;
        CFG_MAX_TRIES:     cfg_d.max_tries       = cfg_data_i[7:0];
        CFG_CHECK_INTERVAL: begin
          cfg_d.check_s  = check_eff;
          cfg_d.check_ms = SecMsW'(check_eff) * SecMsW'(MS_PER_S);
        end
        CFG_BURN_TIME:     cfg_d.burn_ms = SecMsW'(cfg_data_i[7:0]) * SecMsW'(MS_PER_S);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_delay_s <= 16'd1800;
      cfg_q.retry_delay_s   <= 16'd600;
      cfg_q.max_tries       <= 8'd4;
      cfg_q.check_s         <= 8'd10;
      cfg_q.check_ms        <= SecMsW'(10 * MS_PER_S);
      cfg_q.burn_ms         <= SecMsW'(30 * MS_PER_S);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/ads_core.sv]
module ads_core import ads_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  ads_in_t  in_i,
  input  ads_cfg_t cfg_i,
  output ads_out_t res_o
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_HOLD = 3'd1;
  localparam logic [2:0] PH_ON   = 3'd2;
  localparam logic [2:0] PH_BURN = 3'd3;
  localparam logic [2:0] PH_OFF  = 3'd4;

  logic [2:0]          phase_q, phase_d;
  logic [MsW-1:0]      ms_q, ms_d;
  logic [15:0]         elapsed_q, elapsed_d;
  logic [7:0]          tries_q, tries_d;
  logic                enabled_q, enabled_d;
  logic                burn_step_q, burn_step_d;
  logic                pair_odd_q, pair_odd_d;
  logic [AttemptW-1:0] attempts_q, attempts_d;
  logic [3:0]          flags_q, flags_d;

  logic [MsW-1:0] ms_inc;
  logic [16:0]    elapsed_sum;
  logic [15:0]    delay_cur, delay_nxt;
  logic           finish;
  logic           vld, turn_on;
  logic [1:0]     sw;

  function automatic logic [1:0] burner_idx(input logic pair_odd, input logic burn_step);
    logic [1:0] idx;
    if (pair_odd) begin
      idx = {1'b0, burn_step};
    end else begin
      idx = burn_step ? 2'd2 : 2'd3;
    end
    return idx;
  endfunction

  assign ms_inc      = ms_q + MsW'(1);
  assign elapsed_sum = {1'b0, elapsed_q} + 17'(cfg_i.check_s);
  assign delay_cur   = (tries_q == 8'd0) ? cfg_i.initial_delay_s : cfg_i.retry_delay_s;

  always_comb begin
    phase_d     = phase_q;
    ms_d        = ms_q;
    elapsed_d   = elapsed_q;
    tries_d     = tries_q;
    enabled_d   = enabled_q & ~in_i.inhibit_cmd;
    burn_step_d = burn_step_q;
    pair_odd_d  = pair_odd_q;
    attempts_d  = attempts_q;
    flags_d     = flags_q;
    finish      = 1'b0;
    vld         = 1'b0;
    turn_on     = 1'b0;
    sw          = 2'd0;

    case (phase_q)
      PH_WAIT: begin
        if (ms_q == '0 && elapsed_q >= delay_cur) begin
          // Start a try; once the count is used up this try still burns
          // the odd pair and disables further tries.
          if (tries_q == cfg_i.max_tries) begin
            enabled_d  = 1'b0;
            pair_odd_d = 1'b1;
          end else begin
            pair_odd_d = tries_q[0];
            tries_d    = tries_q + 8'd1;
          end
          burn_step_d = 1'b0;
          phase_d     = PH_ON;
          attempts_d  = AttemptW'(1);
          vld         = 1'b1;
          turn_on     = 1'b1;
          sw          = burner_idx(pair_odd_d, 1'b0);
          ms_d        = '0;
        end else if (ms_q == '0 && !enabled_d) begin
          phase_d = PH_HOLD;
          ms_d    = MsW'(1);
        end else if (ms_inc >= MsW'(cfg_i.check_ms)) begin
          elapsed_d = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
          ms_d      = '0;
        end else begin
          ms_d = ms_inc;
        end
      end
      PH_HOLD: begin
        if (ms_q >= MsW'(HOLD_MS)) begin
          phase_d   = PH_WAIT;
          elapsed_d = 16'd0;
          ms_d      = '0;
        end else begin
          ms_d = ms_inc;
        end
      end
      PH_ON, PH_OFF: begin
        if (ms_q == '0) begin
          // The tick right after a command carries its acknowledgement.
          if (in_i.switch_ok) begin
            if (phase_q == PH_ON) begin
              flags_d = flags_q | (4'd1 << burner_idx(pair_odd_q, burn_step_q));
            end else begin
              flags_d = flags_q & ~(4'd1 << burner_idx(pair_odd_q, burn_step_q));
            end
            finish = 1'b1;
          end else begin
            ms_d = MsW'(1);
          end
        end else if (ms_q >= MsW'(RETRY_GAP_MS)) begin
          if (attempts_q < AttemptW'(SWITCH_ATTEMPTS)) begin
            attempts_d = attempts_q + AttemptW'(1);
            vld        = 1'b1;
            turn_on    = (phase_q == PH_ON);
            sw         = burner_idx(pair_odd_q, burn_step_q);
            ms_d       = '0;
          end else begin
            finish = 1'b1;
          end
        end else begin
          ms_d = ms_inc;
        end
      end
      PH_BURN: begin
        if (ms_inc >= MsW'(cfg_i.burn_ms)) begin
          phase_d    = PH_OFF;
          attempts_d = AttemptW'(1);
          vld        = 1'b1;
          turn_on    = 1'b0;
          sw         = burner_idx(pair_odd_q, burn_step_q);
          ms_d       = '0;
        end else begin
          ms_d = ms_inc;
        end
      end
      default: begin
        phase_d   = PH_WAIT;
        elapsed_d = 16'd0;
        ms_d      = '0;
      end
    endcase

    if (finish) begin
      if (phase_q == PH_ON) begin
        phase_d = PH_BURN;
        ms_d    = '0;
      end else if (!burn_step_q) begin
        // First burner of the pair is off; turn on the second one.
        burn_step_d = 1'b1;
        phase_d     = PH_ON;
        attempts_d  = AttemptW'(1);
        vld         = 1'b1;
        turn_on     = 1'b1;
        sw          = burner_idx(pair_odd_q, 1'b1);
        ms_d        = '0;
      end else begin
        phase_d   = PH_WAIT;
        elapsed_d = 16'd0;
        ms_d      = '0;
      end
    end
  end

  assign delay_nxt = (tries_d == 8'd0) ? cfg_i.initial_delay_s : cfg_i.retry_delay_s;

  always_comb begin
    res_o.cmd_valid    = vld;
    res_o.cmd_turn_on  = turn_on;
    res_o.cmd_switch   = sw;
    res_o.burners_on   = flags_d;
    res_o.phase_code   = phase_d;
    res_o.tries_used   = tries_d;
    res_o.enabled_flag = enabled_d;
    if (phase_d == PH_WAIT && delay_nxt > elapsed_d) begin
      res_o.wait_left_s = delay_nxt - elapsed_d;
    end else begin
      res_o.wait_left_s = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      ms_q        <= '0;
      elapsed_q   <= 16'd0;
      tries_q     <= 8'd0;
      enabled_q   <= 1'b1;
      burn_step_q <= 1'b0;
      pair_odd_q  <= 1'b0;
      attempts_q  <= '0;
      flags_q     <= 4'd0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      ms_q        <= ms_d;
      elapsed_q   <= elapsed_d;
      tries_q     <= tries_d;
      enabled_q   <= enabled_d;
      burn_step_q <= burn_step_d;
      pair_odd_q  <= pair_odd_d;
      attempts_q  <= attempts_d;
      flags_q     <= flags_d;
    end
  end

  // A command always leaves the sequencer in a switching phase, waiting for its acknowledgement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.cmd_valid |=> ms_q == '0 && (phase_q == PH_ON || phase_q == PH_OFF))
    else $error("command issued without entering a switching phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ON || phase_q == PH_OFF) |->
      (attempts_q >= AttemptW'(1) && attempts_q <= AttemptW'(SWITCH_ATTEMPTS)))
    else $error("switch attempt count out of range");

  // Tries are only counted when a try starts out of the wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && phase_q == PH_WAIT) |=> $stable(tries_q))
    else $error("try count changed outside the wait");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$rose(enabled_q))
    else $error("enable flag was set again after being cleared");

endmodule

[rtl/core/antenna_deploy_sequencer.sv]
// A transaction accepted at a clock edge sits in the input stage; its result is registered into the
// output stage at the edge where the sequencer updates, which waits while the output is stalled.
// Throughput: one tick per clock cycle while the output is not stalled; an empty input stage takes
// a new transaction while a result waits on a stalled output.
// Reset (rst_ni low, asynchronous): sequencer waiting with zero counts, enable flag set,
// configuration registers at their default values, both stages empty.
module antenna_deploy_sequencer import ads_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ads_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ads_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic     in_valid_q, in_valid_d;
  ads_in_t  in_data_q;
  logic     out_valid_q, out_valid_d;
  ads_out_t out_data_q;
  logic     advance, step, in_accept;
  ads_cfg_t cfg;
  ads_out_t res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  ads_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ads_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? step : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

endmodule
